@@ sv/led_matrix_sprite_mover_macros.svh @@
// Assertion macros shared by the sprite mover modules.
`ifndef LED_MATRIX_SPRITE_MOVER_MACROS_SVH
`define LED_MATRIX_SPRITE_MOVER_MACROS_SVH

`ifndef SYNTHESIS
`define LMSM_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define LMSM_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define LMSM_ASSERT_IMP(label, clk, rst, cond, prop)
`define LMSM_ASSERT_NXT(label, clk, rst, cond, prop)
`endif

`endif

@@ sv/lmsm_pkg.sv @@
// Types and constants of the LED matrix sprite mover.
package lmsm_pkg;

   localparam int PERIOD_W = 10;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;

   localparam logic [7:0] ROW_BLANK = 8'h00;
   localparam logic [7:0] ROW_RING  = 8'h3C;
   localparam logic [7:0] ROW_HOLE  = 8'h24;
   localparam logic [7:0] COL_LEFT  = 8'h80;
   localparam logic [7:0] COL_RIGHT = 8'h01;

   typedef enum logic [2:0] {
      MS_WAIT    = 3'd0,
      MS_UP      = 3'd1,
      MS_DOWN    = 3'd2,
      MS_LEFT    = 3'd3,
      MS_RIGHT   = 3'd4,
      MS_RELEASE = 3'd5,
      MS_START   = 3'd6
   } mover_state_type;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
   } btn_type;

   typedef struct packed {
      logic    advance;
      btn_type btn;
   } step_type;

   function automatic logic [7:0] init_row(input int unsigned idx);
      logic [7:0] r;
      case (idx)
         1, 3:    r = ROW_RING;
         2:       r = ROW_HOLE;
         default: r = ROW_BLANK;
      endcase
      return r;
   endfunction

endpackage

@@ sv/lmsm_mover.sv @@
// Pattern store, mover state machine and run countdown.
`include "led_matrix_sprite_mover_macros.svh"

module lmsm_mover #(
   parameter int ROW_COUNT = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lmsm_pkg::step_type               step,
   input  logic [lmsm_pkg::PERIOD_W-1:0]    move_period,
   output logic [ROW_COUNT-1:0][7:0]        rows_view
);
   import lmsm_pkg::*;

   logic [ROW_COUNT-1:0][7:0] rows_ff, rows_in;
   mover_state_type           state_ff, state_in;
   logic [PERIOD_W-1:0]       count_ff, count_in;
   logic                      run;
   logic                      any_btn;
   logic [7:0]                col_or;

   assign run     = (count_ff == '0);
   assign any_btn = |step.btn;

   always_comb begin
      col_or = '0;
      for (int i = 0; i < ROW_COUNT; i++) begin
         col_or = col_or | rows_ff[i];
      end
   end

   // next state
   always_comb begin
      case (state_ff)
         MS_WAIT: begin
            if (step.btn.up)         state_in = MS_UP;
            else if (step.btn.down)  state_in = MS_DOWN;
            else if (step.btn.left)  state_in = MS_LEFT;
            else if (step.btn.right) state_in = MS_RIGHT;
            else                     state_in = MS_WAIT;
         end
         MS_UP, MS_DOWN, MS_LEFT, MS_RIGHT: state_in = MS_RELEASE;
         MS_RELEASE: state_in = any_btn ? MS_RELEASE : MS_WAIT;
         default: state_in = MS_WAIT;
      endcase
   end

   // pattern shift
   always_comb begin
      rows_in = rows_ff;
      case (state_ff)
         MS_UP: begin
            if (rows_ff[0] == ROW_BLANK) begin
               for (int i = 0; i < ROW_COUNT - 1; i++) rows_in[i] = rows_ff[i+1];
               rows_in[ROW_COUNT-1] = ROW_BLANK;
            end
         end
         MS_DOWN: begin
            if (rows_ff[ROW_COUNT-1] == ROW_BLANK) begin
               for (int i = 1; i < ROW_COUNT; i++) rows_in[i] = rows_ff[i-1];
               rows_in[0] = ROW_BLANK;
            end
         end
         MS_LEFT: begin
            if ((col_or & COL_LEFT) == '0) begin
               for (int i = 0; i < ROW_COUNT; i++) rows_in[i] = {rows_ff[i][6:0], 1'b0};
            end
         end
         MS_RIGHT: begin
            if ((col_or & COL_RIGHT) == '0) begin
               for (int i = 0; i < ROW_COUNT; i++) rows_in[i] = {1'b0, rows_ff[i][7:1]};
            end
         end
         default: rows_in = rows_ff;
      endcase
   end

   assign count_in  = run ? ((move_period == '0) ? '0 : move_period - 1'b1)
                          : count_ff - 1'b1;
   assign rows_view = run ? rows_in : rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_COUNT; i++) rows_ff[i] <= init_row(i);
         state_ff <= MS_START;
         count_ff <= '0;
      end else if (step.advance) begin
         count_ff <= count_in;
         if (run) begin
            state_ff <= state_in;
            rows_ff  <= rows_in;
         end
      end
   end

   `LMSM_ASSERT_NXT(a_release_holds, clock, reset,
      step.advance && run && state_ff == MS_RELEASE && any_btn, state_ff == MS_RELEASE)
   `LMSM_ASSERT_NXT(a_idle_keeps, clock, reset,
      !step.advance, $stable(rows_ff) && $stable(state_ff) && $stable(count_ff))
   `LMSM_ASSERT_NXT(a_wait_no_btn, clock, reset,
      step.advance && run && state_ff == MS_WAIT && !any_btn, state_ff == MS_WAIT)

endmodule

@@ sv/lmsm_scan.sv @@
// Row scan index and registered display bytes.
`include "led_matrix_sprite_mover_macros.svh"

module lmsm_scan #(
   parameter int ROW_COUNT = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [ROW_COUNT-1:0][7:0] rows_view,
   output logic [7:0]                column_byte,
   output logic [7:0]                select_byte,
   output logic [2:0]                scan_row
);
   import lmsm_pkg::*;

   localparam int IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       column_ff, column_in;
   logic [7:0]       select_ff, select_in;
   logic [2:0]       row_ff, row_in;
   logic [7:0]       sel_raw;

   function automatic logic [7:0] inv_swap(input logic [7:0] v);
      return ~{v[3:0], v[7:4]};
   endfunction

   assign idx_in    = (idx_ff == IDX_W'(ROW_COUNT - 1)) ? '0 : idx_ff + 1'b1;
   assign sel_raw   = (32'(idx_ff) < 8) ? ~(8'd1 << idx_ff) : 8'hFF;
   assign column_in = inv_swap(rows_view[idx_ff]);
   assign select_in = inv_swap(sel_raw);
   assign row_in    = 3'(idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (advance) begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         column_ff <= column_in;
         select_ff <= select_in;
         row_ff    <= row_in;
      end
   end

   assign column_byte = column_ff;
   assign select_byte = select_ff;
   assign scan_row    = row_ff;

   `LMSM_ASSERT_IMP(a_idx_range, clock, reset, 1'b1, 32'(idx_ff) < ROW_COUNT)
   `LMSM_ASSERT_NXT(a_idx_wrap, clock, reset,
      advance && idx_ff == IDX_W'(ROW_COUNT - 1), idx_ff == '0)
   `LMSM_ASSERT_NXT(a_row_follow, clock, reset, advance, row_ff == $past(row_in))

endmodule

@@ sv/led_matrix_sprite_mover.sv @@
// An accepted req item goes through the input register, then the result register, to its rsp item.
// Throughput: one item per cycle when rsp is not stalled, through a two-deep pipeline.
// The mover runs on the first item after reset and then every move_period items.
// Reset: synchronous, active high; pattern returns to its start image, mover to start,
// scan index and run countdown to zero, move_period to 100.
`include "led_matrix_sprite_mover_macros.svh"

module led_matrix_sprite_mover #(
   parameter int ROW_COUNT = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // btn_up[0], btn_down[1], btn_left[2], btn_right[3], [7:4] unused
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // column_byte[7:0], select_byte[15:8], scan_row[18:16]
   input  logic        csr_wen,
   input  logic [9:0]  csr_wdata    // move_period
);
   import lmsm_pkg::*;

   logic                      in_valid_ff;
   btn_type                   in_btn_ff;
   logic                      rsp_valid_ff;
   logic [PERIOD_W-1:0]       period_ff;
   logic                      advance;
   step_type                  step;
   logic [ROW_COUNT-1:0][7:0] rows_view;
   logic [7:0]                column_byte;
   logic [7:0]                select_byte;
   logic [2:0]                scan_row;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign step.advance = advance;
   assign step.btn     = in_btn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_wen) period_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_btn_ff.up    <= req_tdata[0];
         in_btn_ff.down  <= req_tdata[1];
         in_btn_ff.left  <= req_tdata[2];
         in_btn_ff.right <= req_tdata[3];
      end
   end

   lmsm_mover #(.ROW_COUNT(ROW_COUNT)) u_mover (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .move_period (period_ff),
      .rows_view   (rows_view)
   );

   lmsm_scan #(.ROW_COUNT(ROW_COUNT)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rows_view   (rows_view),
      .column_byte (column_byte),
      .select_byte (select_byte),
      .scan_row    (scan_row)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, scan_row, select_byte, column_byte};

   `LMSM_ASSERT_NXT(a_adv_gives_rsp, clock, reset, advance, rsp_tvalid)
   `LMSM_ASSERT_NXT(a_in_held, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_btn_ff))
   `LMSM_ASSERT_IMP(a_no_overrun, clock, reset,
      rsp_valid_ff && !rsp_tready, !advance)

endmodule

@@ verif/led_matrix_sprite_mover_checker.sv @@
// Checker for the LED matrix sprite mover: tracks the pattern and checks each scan item.
`timescale 1ns / 1ps

module led_matrix_sprite_mover_checker #(
   parameter int ROW_COUNT = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [23:0]                   rsp_tdata,
   input  logic                          csr_wen,
   input  logic [lmsm_pkg::PERIOD_W-1:0] csr_wdata,
   output int                            pending,
   output int                            errors
);
   import lmsm_pkg::*;

   typedef struct packed {
      logic [7:0] column;
      logic [7:0] select;
      logic [2:0] row;
   } scan_out_type;

   logic [7:0]          pattern [ROW_COUNT];
   mover_state_type     mover;
   logic [PERIOD_W-1:0] countdown;
   logic [PERIOD_W-1:0] period;
   int                  scan_idx;
   scan_out_type        scan_queue [$];

   function automatic logic [7:0] flip_nibbles(input logic [7:0] v);
      return ~{v[3:0], v[7:4]};
   endfunction

   task automatic clear_pattern();
      for (int i = 0; i < ROW_COUNT; i++) pattern[i] = ROW_BLANK;
      pattern[1] = ROW_RING;
      pattern[2] = ROW_HOLE;
      pattern[3] = ROW_RING;
      mover     = MS_START;
      countdown = '0;
      period    = PERIOD_RESET;
      scan_idx  = 0;
   endtask

   task automatic run_mover(input btn_type b);
      logic [7:0] col_or;
      col_or = '0;
      for (int i = 0; i < ROW_COUNT; i++) col_or |= pattern[i];
      case (mover)
         MS_WAIT: begin
            if (b.up) mover = MS_UP;
            else if (b.down) mover = MS_DOWN;
            else if (b.left) mover = MS_LEFT;
            else if (b.right) mover = MS_RIGHT;
            else mover = MS_WAIT;
         end
         MS_UP: begin
            if (pattern[0] == ROW_BLANK) begin
               for (int i = 0; i < ROW_COUNT - 1; i++) pattern[i] = pattern[i+1];
               pattern[ROW_COUNT-1] = ROW_BLANK;
            end
            mover = MS_RELEASE;
         end
         MS_DOWN: begin
            if (pattern[ROW_COUNT-1] == ROW_BLANK) begin
               for (int i = ROW_COUNT - 1; i > 0; i--) pattern[i] = pattern[i-1];
               pattern[0] = ROW_BLANK;
            end
            mover = MS_RELEASE;
         end
         MS_LEFT: begin
            if ((col_or & COL_LEFT) == '0)
               for (int i = 0; i < ROW_COUNT; i++) pattern[i] = pattern[i] << 1;
            mover = MS_RELEASE;
         end
         MS_RIGHT: begin
            if ((col_or & COL_RIGHT) == '0)
               for (int i = 0; i < ROW_COUNT; i++) pattern[i] = pattern[i] >> 1;
            mover = MS_RELEASE;
         end
         MS_RELEASE: begin
            mover = (b != '0) ? MS_RELEASE : MS_WAIT;
         end
         default: begin
            mover = MS_WAIT;
         end
      endcase
   endtask

   task automatic advance_tick(input btn_type b, output scan_out_type r);
      logic [7:0] sel;
      if (countdown == '0) begin
         run_mover(b);
         countdown = (period == '0) ? '0 : period - 1'b1;
      end else begin
         countdown = countdown - 1'b1;
      end
      sel      = ~(8'h01 << scan_idx);
      r.column = flip_nibbles(pattern[scan_idx]);
      r.select = flip_nibbles(sel);
      r.row    = scan_idx[2:0];
      scan_idx = (scan_idx == ROW_COUNT - 1) ? 0 : scan_idx + 1;
   endtask

   always @(posedge clock) begin
      btn_type      b;
      scan_out_type got;
      scan_out_type want;
      if (reset) begin
         clear_pattern();
         scan_queue.delete();
         errors = 0;
         pending <= 0;
      end else begin
         if (csr_wen) period = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.column = rsp_tdata[7:0];
            got.select = rsp_tdata[15:8];
            got.row    = rsp_tdata[18:16];
            if (scan_queue.size() == 0) begin
               $error("unexpected scan item: %06h", rsp_tdata);
               errors++;
            end else begin
               want = scan_queue.pop_front();
               if (got.column !== want.column) begin
                  $error("column_byte: expected %02h, got %02h", want.column, got.column);
                  errors++;
               end
               if (got.select !== want.select) begin
                  $error("select_byte: expected %02h, got %02h", want.select, got.select);
                  errors++;
               end
               if (got.row !== want.row) begin
                  $error("scan_row: expected %0d, got %0d", want.row, got.row);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            b.up    = req_tdata[0];
            b.down  = req_tdata[1];
            b.left  = req_tdata[2];
            b.right = req_tdata[3];
            advance_tick(b, want);
            scan_queue.push_back(want);
         end
         pending <= scan_queue.size();
      end
   end

endmodule

@@ verif/tb_top.sv @@
// Top of the sprite mover testbench: clock, reset, button stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import lmsm_pkg::*;

   localparam int ROWS = 5;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;    // btn_up[0], btn_down[1], btn_left[2], btn_right[3], [7:4] zero
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;          // column_byte[7:0], select_byte[15:8], scan_row[18:16], [23:19] zero
   logic                csr_wen    = 1'b0;
   logic [PERIOD_W-1:0] csr_wdata  = '0;    // move_period

   int pending;
   int errors;
   int sent_items = 0;
   int mid_period;
   bit no_idle    = 1'b0;
   bit hold_ask   = 1'b0;
   bit hold_taken = 1'b0;

   led_matrix_sprite_mover #(.ROW_COUNT(ROWS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   led_matrix_sprite_mover_checker #(.ROW_COUNT(ROWS)) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .errors     (errors)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // scan item sink: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 35);
         end
      end
   end

   task automatic send_item(input logic [3:0] btn);
      while (!no_idle && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, btn};
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] value);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // press, hold, optional glitch, release
   task automatic press_and_release(input int period);
      logic [3:0] btn;
      int         span;
      int         hold_len;
      int         rel_len;
      span     = (period < 1) ? 1 : ((period > 4) ? 4 : period);
      btn      = 4'b0001 << $urandom_range(3);
      if ($urandom_range(99) < 20) btn = 4'($urandom_range(1, 15));
      hold_len = $urandom_range(1, 2 * span + 1);
      rel_len  = $urandom_range(1, 2 * span + 1);
      repeat (hold_len) send_item(btn);
      if ($urandom_range(99) < 15) send_item(4'($urandom_range(15)));
      repeat (rel_len) send_item(4'b0);
   endtask

   task automatic run_phase(input int count, input int period);
      int stop_at;
      stop_at = sent_items + count;
      while (sent_items < stop_at) begin
         if ($urandom_range(99) < 80) press_and_release(period);
         else send_item(4'($urandom_range(15)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start tick ignores the buttons; then each button alone and together
      send_item(4'b1111);
      send_item(4'b0000);
      send_item(4'b0001);
      send_item(4'b0010);
      send_item(4'b0100);
      send_item(4'b1000);
      send_item(4'b1111);
      send_item(4'b0011);
      send_item(4'b1100);
      send_item(4'b0101);
      send_item(4'b1010);
      send_item(4'b0000);

      write_period(10'd1);
      hold_ask = 1'b1;
      run_phase(300, 1);
      wait_drained();
      run_phase(300, 1);

      write_period(10'd0);
      no_idle = 1'b1;
      run_phase(250, 0);
      no_idle = 1'b0;
      run_phase(250, 0);

      mid_period = $urandom_range(2, 6);
      write_period(mid_period[PERIOD_W-1:0]);
      run_phase(500, mid_period);

      write_period(10'd1023);
      run_phase(80, 1023);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Run covered %0d button items with move periods 100, 1, 0, %0d and 1023,",
               sent_items, mid_period);
      $display("random stalls on both sides, a long sink hold-off and a drained pause.");
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
